@@ hdl/mts_pkg.sv @@
`timescale 1ns / 1ps

package mts_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_MIN  = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage

@@ hdl/min_tracking_stack.sv @@
`timescale 1ns / 1ps

// Stack of signed 32-bit values that also reports the smallest value held.
// Command channel: drive i_operation (push, pop, min query) and i_value,
// raise start; the command is taken at a clock edge where start is high
// and busy is low. Each stored entry carries the running minimum at its
// depth, so every command touches only the top entry and the fill count.
// Result channel: o_data and o_status appear for exactly one cycle with
// o_valid high, driven from result registers written as the execute state
// that follows acceptance ends. The receiver cannot stall; a result not
// captured in its cycle is gone.
// Commands do not overlap: busy holds off a new command while the execute
// state, after the registered read of the top entry, updates the fill count.
// Pop and min on an empty stack return status empty, push on a full stack
// is dropped with status full; error results carry zero data.
// Reset (i_rst_n low, synchronous) empties the stack and clears the
// controller; stack RAM contents are left as they are and never used
// above the fill count, so no clearing pass is needed.

module min_tracking_stack (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_operation,
    input  logic signed [mts_pkg::DATA_W-1:0]  i_value,
    output logic signed [mts_pkg::DATA_W-1:0]  o_data,
    output logic [1:0]                         o_status,
    output logic                               o_valid
);

    mts_pkg::t_cmd cmd;

    mts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    mts_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_operation (i_operation),
        .i_value     (i_value),
        .o_data      (o_data),
        .o_status    (o_status),
        .o_valid     (o_valid)
    );

endmodule

@@ hdl/mts_ctrl.sv @@
`timescale 1ns / 1ps

module mts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output mts_pkg::t_cmd o_cmd
);

    mts_pkg::t_state r_state;
    mts_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mts_pkg::S_IDLE: begin
                if (start) begin
                    n_state = mts_pkg::S_EXEC;
                end
            end
            mts_pkg::S_EXEC: begin
                n_state = mts_pkg::S_IDLE;
            end
            default: begin
                n_state = mts_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        busy       = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        case (r_state)
            mts_pkg::S_IDLE: begin
                o_cmd.load = start;
            end
            mts_pkg::S_EXEC: begin
                busy       = 1'b1;
                o_cmd.exec = 1'b1;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

@@ hdl/mts_dp.sv @@
`timescale 1ns / 1ps

module mts_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mts_pkg::t_cmd                      i_cmd,
    input  logic [1:0]                         i_operation,
    input  logic signed [mts_pkg::DATA_W-1:0]  i_value,
    output logic signed [mts_pkg::DATA_W-1:0]  o_data,
    output logic [1:0]                         o_status,
    output logic                               o_valid
);

    logic signed [mts_pkg::DATA_W-1:0] mem_val [mts_pkg::STACK_DEPTH];
    logic signed [mts_pkg::DATA_W-1:0] mem_min [mts_pkg::STACK_DEPTH];

    mts_pkg::t_op                      r_op;
    logic signed [mts_pkg::DATA_W-1:0] r_value;
    logic [mts_pkg::FILL_W-1:0]        r_fill;
    logic [mts_pkg::FILL_W-1:0]        n_fill;
    logic signed [mts_pkg::DATA_W-1:0] r_rd_val;
    logic signed [mts_pkg::DATA_W-1:0] r_rd_min;
    logic signed [mts_pkg::DATA_W-1:0] r_data;
    logic signed [mts_pkg::DATA_W-1:0] n_data;
    logic [1:0]                        r_status;
    mts_pkg::t_status                  n_status;
    logic                              r_valid;

    logic                              is_empty;
    logic                              is_full;
    logic                              wr_en;
    logic signed [mts_pkg::DATA_W-1:0] wr_min;
    logic [mts_pkg::FILL_W-1:0]        fill_dec;
    logic [mts_pkg::ADDR_W-1:0]        rd_addr;
    logic [mts_pkg::ADDR_W-1:0]        wr_addr;

    assign is_empty = (r_fill == '0);
    assign is_full  = (r_fill == mts_pkg::FILL_W'(mts_pkg::STACK_DEPTH));
    assign fill_dec = r_fill - mts_pkg::FILL_W'(1);
    assign rd_addr  = fill_dec[mts_pkg::ADDR_W-1:0];
    assign wr_addr  = r_fill[mts_pkg::ADDR_W-1:0];
    assign wr_en    = i_cmd.exec && (r_op == mts_pkg::OP_PUSH) && !is_full;
    assign wr_min   = (!is_empty && (r_rd_min < r_value)) ? r_rd_min : r_value;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_val[wr_addr] <= r_value;
            mem_min[wr_addr] <= wr_min;
        end
        r_rd_val <= mem_val[rd_addr];
        r_rd_min <= mem_min[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= mts_pkg::t_op'(i_operation);
            r_value <= i_value;
        end
        if (i_cmd.exec) begin
            r_data   <= n_data;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_fill   = r_fill;
        n_data   = '0;
        n_status = mts_pkg::ST_OK;
        case (r_op)
            mts_pkg::OP_PUSH: begin
                if (is_full) begin
                    n_status = mts_pkg::ST_FULL;
                end else begin
                    n_fill = r_fill + mts_pkg::FILL_W'(1);
                end
            end
            mts_pkg::OP_POP: begin
                if (is_empty) begin
                    n_status = mts_pkg::ST_EMPTY;
                end else begin
                    n_fill = fill_dec;
                    n_data = r_rd_val;
                end
            end
            mts_pkg::OP_MIN: begin
                if (is_empty) begin
                    n_status = mts_pkg::ST_EMPTY;
                end else begin
                    n_data = r_rd_min;
                end
            end
            default: begin
                n_status = mts_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.exec;
            if (i_cmd.exec) begin
                r_fill <= n_fill;
            end
        end
    end

    assign o_data   = r_data;
    assign o_status = r_status;
    assign o_valid  = r_valid;

endmodule
